>>> hw/rtl/fixed_point_q24_8_alu_core_assert.svh
// assertion macros used by the fpa_checker file
`ifndef FIXED_POINT_Q24_8_ALU_CORE_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_CORE_ASSERT_SVH

// clocked assertion that is idle while reset is low
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define FPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// types and codes shared by the fixed point alu modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_INC      = 4'd10,
    OP_DEC      = 4'd11,
    OP_MIN      = 4'd12,
    OP_MAX      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } opcode_t;

  // classification made at accept time
  typedef struct packed {
    logic is_div;
    logic is_mul;
    logic is_cmp;
  } op_class_t;

  // one queued transaction
  typedef struct packed {
    opcode_t          op;
    op_class_t        cls;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } q_entry_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

>>> hw/rtl/fixed_point_q24_8_alu_core.sv
// non-divide path: queue, execute stage register and result register to out_valid
// divide: the shared iterative divider gives one bit a cycle
// throughput: one transaction per cycle while no divide is in the execute unit
// a divide holds later transactions in the 4-entry queue; busy shows it is full
// reset: synchronous active low rst_n empties the queue and the divider
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core
// signed fixed point alu with a queued front end and in-order execute unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_core import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [3:0]       in_opcode,
  input  logic [DataW-1:0] in_operand_a,
  input  logic [DataW-1:0] in_operand_b,
  output logic             out_valid,
  output logic [DataW-1:0] out_result_value,
  output logic             out_compare_flag,
  output logic             out_divide_by_zero
);

  q_head_t head;
  logic    pop;

  // accept and queue
  fpa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .head         (head),
    .pop          (pop)
  );

  // execute
  fpa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_result_value   (out_result_value),
    .out_compare_flag   (out_compare_flag),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

>>> hw/rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// accepts transactions, classifies the opcode and queues them for execution
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_front import fpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [3:0]       in_opcode,
  input  logic [DataW-1:0] in_operand_a,
  input  logic [DataW-1:0] in_operand_b,
  output q_head_t          head,
  input  logic             pop
);

  q_entry_t           mem_r [QDepth];
  logic [QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPtrW:0]     count_r, count_nxt;
  logic               push;
  logic               do_pop;
  q_entry_t           new_entry;
  opcode_t            op;

  assign busy   = (count_r == (QPtrW+1)'(QDepth));
  assign push   = start && !busy;
  assign do_pop = pop && (count_r != '0);

  // opcode classification
  always_comb begin
    op = opcode_t'(in_opcode);
    new_entry.op = op;
    new_entry.a  = in_operand_a;
    new_entry.b  = in_operand_b;
    new_entry.cls.is_div = (op == OP_DIV);
    new_entry.cls.is_mul = (op == OP_MUL);
    new_entry.cls.is_cmp = op inside {[OP_GT:OP_NE]};
  end

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPtrW+1)'(push) - (QPtrW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

endmodule

>>> hw/rtl/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_div import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DataW-1:0] num,
  input  logic [DataW-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [DataW-1:0] quot
);

  localparam int unsigned DivW = DataW + FRAC_BITS;
  localparam int unsigned RemW = DataW + 1;
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [RemW-1:0] rem_r, rem_nxt;
  logic [DivW-1:0] quo_r, quo_nxt;
  logic [DataW-1:0] den_r;
  logic            neg_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] rem_sub;
  logic [RemW-1:0] num_mag;
  logic [RemW-1:0] den_mag;

  // operand magnitudes
  always_comb begin
    num_mag = num[DataW-1] ? RemW'(0) - {1'b1, num} : {1'b0, num};
    den_mag = den[DataW-1] ? RemW'(0) - {1'b1, den} : {1'b0, den};
  end

  // one restoring step
  always_comb begin
    rem_sh   = {rem_r[RemW-2:0], quo_r[DivW-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt  = '0;
      quo_nxt  = {num_mag[DataW-1:0], FRAC_BITS'(0)};
      cnt_nxt  = CntW'(DivW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sub;
        quo_nxt = {quo_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (go) begin
      den_r <= den_mag[DataW-1:0];
      neg_r <= num[DataW-1] ^ den[DataW-1];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = neg_r ? DataW'(0) - quo_r[DataW-1:0] : quo_r[DataW-1:0];

endmodule

>>> hw/rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// executes queued transactions in order and drives the result strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_back import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_head_t          head,
  output logic             pop,
  output logic             out_valid,
  output logic [DataW-1:0] out_result_value,
  output logic             out_compare_flag,
  output logic             out_divide_by_zero
);

  localparam int unsigned ProdW = 2 * DataW;

  logic                    div_go;
  logic                    div_busy;
  logic                    div_done;
  logic [DataW-1:0]        div_quot;

  logic                    p_valid_r;
  logic                    p_is_mul_r;
  logic signed [ProdW-1:0] p_prod_r;
  logic [DataW-1:0]        p_res_r;
  logic                    p_flag_r;
  logic                    p_dz_r;

  logic [DataW-1:0]        res_c;
  logic                    flag_c;
  logic                    dz_c;
  logic signed [DataW-1:0] sa;
  logic signed [DataW-1:0] sb;
  logic [DataW:0]          mag;
  logic [DataW:0]          mag_sh;
  logic signed [ProdW-1:0] prod_c;
  logic signed [ProdW-1:0] prod_sh;

  logic                    out_valid_r;
  logic [DataW-1:0]        out_res_r;
  logic                    out_flag_r;
  logic                    out_dz_r;

  // issue one transaction a cycle unless the divider is working
  assign pop    = head.valid && !div_busy;
  assign div_go = pop && head.entry.cls.is_div && (head.entry.b != '0);

  // single cycle operations
  always_comb begin
    sa     = signed'(head.entry.a);
    sb     = signed'(head.entry.b);
    prod_c = ProdW'(sa) * ProdW'(sb);
    mag    = '0;
    mag_sh = '0;
    res_c  = '0;
    flag_c = 1'b0;
    dz_c   = 1'b0;
    case (head.entry.op)
      OP_ADD:  res_c = head.entry.a + head.entry.b;
      OP_SUB:  res_c = head.entry.a - head.entry.b;
      OP_MUL:  res_c = '0;
      OP_DIV:  dz_c  = (head.entry.b == '0);
      OP_GT:   flag_c = (sa > sb);
      OP_LT:   flag_c = (sa < sb);
      OP_GE:   flag_c = (sa >= sb);
      OP_LE:   flag_c = (sa <= sb);
      OP_EQ:   flag_c = (sa == sb);
      OP_NE:   flag_c = (sa != sb);
      OP_INC:  res_c = head.entry.a + DataW'(1);
      OP_DEC:  res_c = head.entry.a - DataW'(1);
      OP_MIN:  res_c = (sa < sb) ? head.entry.a : head.entry.b;
      OP_MAX:  res_c = (sa > sb) ? head.entry.a : head.entry.b;
      OP_TO_INT: begin
        if (head.entry.a[DataW-1]) begin
          mag    = (DataW+1)'(0) - {1'b1, head.entry.a};
          mag_sh = mag >> FRAC_BITS;
          res_c  = DataW'(0) - mag_sh[DataW-1:0];
        end else begin
          res_c = head.entry.a >> FRAC_BITS;
        end
      end
      OP_FROM_INT: res_c = head.entry.a << FRAC_BITS;
      default: res_c = '0;
    endcase
  end

  // execute stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= pop && !div_go;
    end
  end

  always_ff @(posedge clk) begin
    p_is_mul_r <= head.entry.cls.is_mul;
    p_prod_r   <= prod_c;
    p_res_r    <= res_c;
    p_flag_r   <= flag_c;
    p_dz_r     <= dz_c;
  end

  // product scaling
  assign prod_sh = p_prod_r >>> FRAC_BITS;

  // result register, divider finishes only while the execute stage is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p_valid_r || div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      out_res_r  <= div_quot;
      out_flag_r <= 1'b0;
      out_dz_r   <= 1'b0;
    end else begin
      out_res_r  <= p_is_mul_r ? prod_sh[DataW-1:0] : p_res_r;
      out_flag_r <= p_flag_r;
      out_dz_r   <= p_dz_r;
    end
  end

  fpa_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (head.entry.a),
    .den   (head.entry.b),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid          = out_valid_r;
  assign out_result_value   = out_res_r;
  assign out_compare_flag   = out_flag_r;
  assign out_divide_by_zero = out_dz_r;

endmodule

>>> hw/rtl/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker
// port level checks on the fixed point alu result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_point_q24_8_alu_core_assert.svh"

module fpa_checker import fpa_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [DataW-1:0] out_result_value,
  input logic             out_compare_flag,
  input logic             out_divide_by_zero
);

  // no result strobe right after reset
  `FPA_ASSERT_ALWAYS(a_no_out_after_reset, clk, !rst_n |=> !out_valid, "strobe after reset")

  // a zero divisor transaction carries a zero result
  `FPA_ASSERT(a_dz_zero, clk, rst_n, out_valid && out_divide_by_zero |-> out_result_value == '0, "dz result not zero")

  // a comparison never flags a zero divisor
  `FPA_ASSERT(a_flag_excl, clk, rst_n, out_valid |-> !(out_compare_flag && out_divide_by_zero), "flag and dz together")

  // busy does not rise unless a start arrived while the queue was not full
  `FPA_ASSERT(a_busy_after_idle, clk, rst_n, $past(!busy) && $past(!start) |-> !busy, "busy without traffic")

endmodule

bind fixed_point_q24_8_alu_core fpa_checker u_fpa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_result_value   (out_result_value),
  .out_compare_flag   (out_compare_flag),
  .out_divide_by_zero (out_divide_by_zero)
);

>>> bench/fixed_point_q24_8_alu_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core_checker
// watches accepted operations and result strobes, computes the expected q24.8
// result of each operation and compares it field by field in arrival order
// ----------------------------------------------------------------------------

module fixed_point_q24_8_alu_core_checker import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [3:0]       in_opcode,
  input  logic [DataW-1:0] in_operand_a,
  input  logic [DataW-1:0] in_operand_b,
  input  logic             out_valid,
  input  logic [DataW-1:0] out_result_value,
  input  logic             out_compare_flag,
  input  logic             out_divide_by_zero,
  output int               fail_count,
  output int               pending_count
);

  typedef struct packed {
    logic [31:0] value;
    logic        flag;
    logic        dz;
  } alu_result_t;

  alu_result_t expected_results[$];

  // arithmetic of one operation
  function automatic alu_result_t alu_compute(opcode_t op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] wide;
    logic [31:0] mag;
    r = '0;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: begin
        wide = 64'(a) * 64'(b);
        wide = wide >>> FRAC_BITS;
        r.value = wide[31:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          wide = 64'(a) <<< FRAC_BITS;
          wide = wide / 64'(b);
          r.value = wide[31:0];
        end
      end
      OP_GT: r.flag = a > b;
      OP_LT: r.flag = a < b;
      OP_GE: r.flag = a >= b;
      OP_LE: r.flag = a <= b;
      OP_EQ: r.flag = a == b;
      OP_NE: r.flag = a != b;
      OP_INC: r.value = a + 32'sd1;
      OP_DEC: r.value = a - 32'sd1;
      OP_MIN: r.value = (a < b) ? a : b;
      OP_MAX: r.value = (a > b) ? a : b;
      OP_TO_INT: begin
        if (a < 0) begin
          mag = 32'd0 - a;
          r.value = 32'd0 - (mag >> FRAC_BITS);
        end else begin
          r.value = a >> FRAC_BITS;
        end
      end
      default: r.value = a << FRAC_BITS;
    endcase
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // predict on accept, compare on strobe
  always @(posedge clk) begin
    alu_result_t exp_r;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result with no operation outstanding: value %h", out_result_value);
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_result_value !== exp_r.value) begin
            $error("result_value expected %h actual %h", exp_r.value, out_result_value);
            errs++;
          end
          if (out_compare_flag !== exp_r.flag) begin
            $error("compare_flag expected %b actual %b", exp_r.flag, out_compare_flag);
            errs++;
          end
          if (out_divide_by_zero !== exp_r.dz) begin
            $error("divide_by_zero expected %b actual %b", exp_r.dz, out_divide_by_zero);
            errs++;
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(alu_compute(opcode_t'(in_opcode), in_operand_a,
                                               in_operand_b));
      fail_count <= fail_count + errs;
    end
  end

endmodule

>>> bench/fixed_point_q24_8_alu_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core_test
// drives directed corner operations then random ones with random gaps into
// the alu; the checker predicts and compares every result
// ----------------------------------------------------------------------------

module fixed_point_q24_8_alu_core_test;
  import fpa_pkg::*;

  localparam int RandomOps = 1500;
  localparam int CycleLimit = 400000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [3:0]       in_opcode;
  logic [DataW-1:0] in_operand_a;
  logic [DataW-1:0] in_operand_b;
  logic             out_valid;
  logic [DataW-1:0] out_result_value;
  logic             out_compare_flag;
  logic             out_divide_by_zero;
  int               fail_count;
  int               pending_count;
  int               cycle_count = 0;

  fixed_point_q24_8_alu_core dut (.*);
  fixed_point_q24_8_alu_core_checker checker_i (.*);

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // present one transaction and hold it until accepted
  task automatic issue_op(opcode_t op, logic [31:0] a, logic [31:0] b);
    start <= 1'b1;
    in_opcode <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // idle cycles between transactions, mostly short, a few long
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 99) < 50) ? 0 :
        ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // operand with a bias toward corners
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 6)) - 32'd3;
      3: return 32'($signed(16'($urandom)));
      4: return 32'($urandom_range(0, 4)) << 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    opcode_t op;
    logic [31:0] a;
    logic [31:0] b;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    for (int k = 0; k < 16; k++)
      issue_op(opcode_t'(k), 32'h0000_0380, 32'hffff_fe80);
    issue_op(OP_DIV, 32'h0000_0500, 32'h0);
    issue_op(OP_DIV, 32'h7fff_ffff, 32'h1);
    issue_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    issue_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    issue_op(OP_MUL, 32'h7fff_ffff, 32'hffff_ffff);
    issue_op(OP_TO_INT, 32'h8000_0000, 32'h0);
    issue_op(OP_TO_INT, 32'hffff_ff01, 32'h0);
    issue_op(OP_ADD, 32'h7fff_ffff, 32'h1);
    issue_op(OP_EQ, 32'h8000_0000, 32'h8000_0000);
    drain();

    // random traffic
    for (int i = 0; i < RandomOps; i++) begin
      op = opcode_t'($urandom_range(0, 15));
      a = pick_operand();
      b = pick_operand();
      issue_op(op, a, b);
      idle_gap();
      if (i == RandomOps / 2) drain();
    end
    drain();
    repeat (80) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
